[hdl/pamac_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial add / multiply accumulator package
// Shared constants, state encoding and the control word that drives the
// row of coefficient cells.
// ----------------------------------------------------------------------------
package pamac_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_DEGREE_DEF = 10;
   localparam int COEF_WIDTH_DEF = 32;

   // Fixed widths of the transaction fields.
   localparam int COEF_FIELD_W = 32;
   localparam int DEG_FIELD_W  = 4;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_MUL,
      ST_EMIT
   } state_type;

   // Control word broadcast to every cell of the row.
   typedef struct packed {
      logic rot_dn;   // every cell takes its upper neighbour's value
      logic rot_up;   // accumulator ring turns the other way, for output
      logic add_acc;  // the selected cell adds the addend to its accumulator
      logic add_pp;   // the selected cell adds the addend to its partial product
      logic commit;   // partial product replaces the accumulator, store clears
   } cell_ctrl_type;

endpackage

[hdl/pamac_intf.sv]
// ----------------------------------------------------------------------------
// Polynomial add / multiply accumulator channels
// Valid / ready channels for term transactions and coefficient transactions.
// ----------------------------------------------------------------------------
interface pamac_req_intf;
   logic                                     valid;
   logic                                     ready;
   logic                                     mode;
   logic signed [pamac_pkg::COEF_FIELD_W-1:0] term_coefficient;
   logic        [pamac_pkg::DEG_FIELD_W-1:0]  term_degree;
   logic                                     last_term;

   modport source (output valid, output mode, output term_coefficient,
                   output term_degree, output last_term, input ready);
   modport sink   (input valid, input mode, input term_coefficient,
                   input term_degree, input last_term, output ready);
endinterface

interface pamac_rsp_intf;
   logic                                     valid;
   logic                                     ready;
   logic signed [pamac_pkg::COEF_FIELD_W-1:0] result_coefficient;
   logic        [pamac_pkg::DEG_FIELD_W-1:0]  result_degree;
   logic                                     result_last;

   modport source (output valid, output result_coefficient, output result_degree,
                   output result_last, input ready);
   modport sink   (input valid, input result_coefficient, input result_degree,
                   input result_last, output ready);
endinterface

[hdl/pamac_cell.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient cell
// Holds one accumulated coefficient and one partial-product coefficient and
// passes them to its neighbours as the row rotates.
// ----------------------------------------------------------------------------
module pamac_cell #(
   parameter int STORE_W = pamac_pkg::COEF_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pamac_pkg::cell_ctrl_type ctrl,
   input  logic                    sel,
   input  logic [STORE_W-1:0]      addend,
   input  logic [STORE_W-1:0]      acc_dn,
   input  logic [STORE_W-1:0]      acc_up,
   input  logic [STORE_W-1:0]      pp_sum_dn,
   output logic [STORE_W-1:0]      acc_q,
   output logic [STORE_W-1:0]      pp_sum
);

   logic [STORE_W-1:0] acc_ff, acc_in;
   logic [STORE_W-1:0] pp_ff, pp_in;
   logic [STORE_W-1:0] acc_sum;

   // Local additions; the partial-product sum is taken before the row shifts.
   assign acc_sum = acc_ff + ((ctrl.add_acc && sel) ? addend : '0);
   assign pp_sum  = pp_ff + ((ctrl.add_pp && sel) ? addend : '0);
   assign acc_q   = acc_ff;

   // Next value of the accumulator coefficient.
   always_comb begin
      if (ctrl.rot_dn) begin
         acc_in = acc_dn;
      end else if (ctrl.rot_up) begin
         acc_in = acc_up;
      end else if (ctrl.commit) begin
         acc_in = pp_sum;
      end else begin
         acc_in = acc_sum;
      end
   end

   // Next value of the partial-product coefficient.
   always_comb begin
      if (ctrl.rot_dn) begin
         pp_in = pp_sum_dn;
      end else if (ctrl.commit) begin
         pp_in = '0;
      end else begin
         pp_in = pp_sum;
      end
   end

   // Coefficient registers, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         pp_ff  <= '0;
      end else begin
         acc_ff <= acc_in;
         pp_ff  <= pp_in;
      end
   end

endmodule

[hdl/pamac_ctrl.sv]
// ----------------------------------------------------------------------------
// Polynomial accumulator sequencer
// Steps the coefficient row through add, multiply and output passes and
// handles the term handshake.
// ----------------------------------------------------------------------------
module pamac_ctrl #(
   parameter int MAX_DEGREE = pamac_pkg::MAX_DEGREE_DEF,
   parameter int CNT_W      = $clog2(MAX_DEGREE + 2)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_mode,
   input  logic                     req_last,
   input  logic                     out_free,
   output logic                     req_ready,
   output pamac_pkg::cell_ctrl_type cell_ctrl,
   output logic                     mul_en,
   output logic                     load_rsp,
   output logic [CNT_W-1:0]         cnt
);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DEGREE);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_DEGREE + 1);

   pamac_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 last_ff, last_in;

   assign cnt = cnt_ff;

   // State, step counter and last-term mark.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pamac_pkg::ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   // Next state and row control.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      mul_en    = 1'b0;
      load_rsp  = 1'b0;
      cell_ctrl = '0;
      unique case (state_ff)
         pamac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in  = req_last;
               cnt_in   = '0;
               state_in = req_mode ? pamac_pkg::ST_MUL : pamac_pkg::ST_ADD;
            end
         end
         pamac_pkg::ST_ADD: begin
            cell_ctrl.add_acc = 1'b1;
            cnt_in            = '0;
            state_in          = last_ff ? pamac_pkg::ST_EMIT : pamac_pkg::ST_IDLE;
         end
         pamac_pkg::ST_MUL: begin
            if (cnt_ff == CNT_END) begin
               // Final product lands with the ring back at home.
               cell_ctrl.add_pp = 1'b1;
               cell_ctrl.commit = last_ff;
               cnt_in           = '0;
               state_in         = last_ff ? pamac_pkg::ST_EMIT : pamac_pkg::ST_IDLE;
            end else begin
               mul_en           = 1'b1;
               cell_ctrl.rot_dn = 1'b1;
               cell_ctrl.add_pp = (cnt_ff != '0);
               cnt_in           = cnt_ff + 1'b1;
            end
         end
         pamac_pkg::ST_EMIT: begin
            if (out_free) begin
               load_rsp         = 1'b1;
               cell_ctrl.rot_up = 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  cnt_in   = '0;
                  state_in = pamac_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = pamac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/polynomial_add_multiply_accumulator.sv]
// ----------------------------------------------------------------------------
// Polynomial add / multiply accumulator
// Accumulates a truncated polynomial from term transactions and returns all
// of its coefficients after each operand's last term.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one term per transaction: mode (0 add, 1 multiply),
//   coefficient, degree and a last-term mark. rsp_ch returns MAX_DEGREE+1
//   coefficient transactions, highest degree first, after every last term;
//   result_last marks the degree-zero coefficient.
// Sequencing:
//   An add term is accepted in the idle state and added in the add state.
//   A multiply term turns the accumulator ring once past a single shared
//   multiplier, one coefficient per cycle, and a final step lands the
//   registered final product.
//   After a last term the ring turns the other way and hands one coefficient
//   a cycle to the output register while the receiver does not stall.
// Reset clears the accumulator and the partial-product store to zero.
// When the receiver stalls, the output register holds its transaction and
// the ring waits; the next term is accepted as soon as the last coefficient
// has entered the output register.
// ----------------------------------------------------------------------------
module polynomial_add_multiply_accumulator #(
   parameter int MAX_DEGREE = pamac_pkg::MAX_DEGREE_DEF,
   parameter int COEF_WIDTH = pamac_pkg::COEF_WIDTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   pamac_req_intf.sink   req_ch,
   pamac_rsp_intf.source rsp_ch
);

   localparam int NUM_COEFS = MAX_DEGREE + 1;
   // Only the low field-width bits of any coefficient reach the output.
   localparam int STORE_W = (COEF_WIDTH < pamac_pkg::COEF_FIELD_W) ?
                            COEF_WIDTH : pamac_pkg::COEF_FIELD_W;
   localparam int CNT_W   = $clog2(MAX_DEGREE + 2);
   localparam int HW      = ((CNT_W > pamac_pkg::DEG_FIELD_W) ?
                             CNT_W : pamac_pkg::DEG_FIELD_W) + 1;
   localparam logic [HW-1:0] MAX_DEG_H = HW'(MAX_DEGREE);

   pamac_pkg::cell_ctrl_type cell_ctrl;
   logic                     mul_en;
   logic                     load_rsp;
   logic                     out_free;
   logic [CNT_W-1:0]         cnt;

   logic [STORE_W-1:0]                   coef_ff;
   logic [pamac_pkg::DEG_FIELD_W-1:0]    deg_ff;
   logic [STORE_W-1:0]                   prod_full;
   logic [STORE_W-1:0]                   prod_ff;
   logic                                 prod_hit_ff, prod_hit_in;
   logic [HW-1:0]                        deg_h;
   logic [HW-1:0]                        deg_sum;
   logic [HW-1:0]                        tgt;
   logic [HW-1:0]                        emit_deg;
   logic [STORE_W-1:0]                   addend;

   logic [STORE_W-1:0] acc_q  [NUM_COEFS];
   logic [STORE_W-1:0] pp_sum [NUM_COEFS];
   logic               sel    [NUM_COEFS];

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pamac_pkg::COEF_FIELD_W-1:0]   rsp_coef_ff;
   logic [pamac_pkg::DEG_FIELD_W-1:0]    rsp_deg_ff;
   logic                                 rsp_last_ff;

   // Sequencer.
   pamac_ctrl #(
      .MAX_DEGREE (MAX_DEGREE),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_last  (req_ch.last_term),
      .out_free  (out_free),
      .req_ready (req_ch.ready),
      .cell_ctrl (cell_ctrl),
      .mul_en    (mul_en),
      .load_rsp  (load_rsp),
      .cnt       (cnt)
   );

   // Term register, loaded with each accepted transaction.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         coef_ff <= req_ch.term_coefficient[STORE_W-1:0];
         deg_ff  <= req_ch.term_degree;
      end
   end

   // Shared multiplier on the head cell; the product is registered and lands
   // in the next cycle in the cell that then holds its target degree.
   assign prod_full   = coef_ff * acc_q[0];
   assign deg_h       = HW'(deg_ff);
   assign deg_sum     = HW'(cnt) + deg_h;
   assign prod_hit_in = mul_en && (deg_sum <= MAX_DEG_H);
   assign tgt         = (deg_h == '0) ? HW'(MAX_DEGREE) : (deg_h - 1'b1);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_hit_ff <= 1'b0;
      end else begin
         prod_hit_ff <= prod_hit_in;
      end
   end

   assign addend = cell_ctrl.add_acc ? coef_ff : prod_ff;

   // Row of coefficient cells, closed into a ring.
   for (genvar k = 0; k < NUM_COEFS; k++) begin : g_cell
      localparam int DN = (k + 1) % NUM_COEFS;
      localparam int UP = (k + NUM_COEFS - 1) % NUM_COEFS;

      assign sel[k] = cell_ctrl.add_acc ? (deg_h == HW'(k)) :
                                          (prod_hit_ff && (tgt == HW'(k)));

      pamac_cell #(
         .STORE_W (STORE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .sel       (sel[k]),
         .addend    (addend),
         .acc_dn    (acc_q[DN]),
         .acc_up    (acc_q[UP]),
         .pp_sum_dn (pp_sum[DN]),
         .acc_q     (acc_q[k]),
         .pp_sum    (pp_sum[k])
      );
   end

   // Output register, fed from the top cell of the ring.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign emit_deg     = MAX_DEG_H - HW'(cnt);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_coef_ff <= pamac_pkg::COEF_FIELD_W'(acc_q[NUM_COEFS-1]);
         rsp_deg_ff  <= pamac_pkg::DEG_FIELD_W'(emit_deg);
         rsp_last_ff <= (cnt == CNT_W'(MAX_DEGREE));
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.result_coefficient = rsp_coef_ff;
   assign rsp_ch.result_degree      = rsp_deg_ff;
   assign rsp_ch.result_last        = rsp_last_ff;

   // Checks on the sequencing.

   // An accepted term always leaves the block busy in the cycle after.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("term accepted on consecutive cycles");

   // The ring never turns both ways, nor turns while committing.
   a_ring_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_ctrl.rot_dn, cell_ctrl.rot_up, cell_ctrl.commit}))
      else $error("conflicting ring controls");

   // A coefficient is only loaded when the output register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("output transaction overwritten");

   // No new term is taken while coefficients are still being handed out.
   a_no_accept_emit: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !req_ch.ready)
      else $error("term accepted during output run");

endmodule
